[rtl/core/assert_macros.svh]
// assertion macros for the ray segment hit core
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSNH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RSNH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSNH_ASSERT_IMP(lbl, ante, cons)
`define RSNH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/rsnh_pkg.sv]
// shared types and constants for the ray segment nearest hit core
// no dependencies
`timescale 1ns / 1ps
package rsnh_pkg;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int DIR_FRAC_BITS_DEF = 14;
  localparam int DIR_WIDTH         = 16;
  localparam int LEN_WIDTH         = 23;
  localparam int THR_WIDTH         = 16;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_TEST,
    S_DIV,
    S_EMIT
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } div_stat_t;
endpackage

[rtl/core/ray_segment_nearest_hit_unit.sv]
// channel | direction | payload
// in_     | slave     | tdata: origin, direction, max length, segment; tuser first; tlast last
// out_    | master    | tdata: distance; tuser: hit
// cfg_    | write     | parallel threshold, 16 bit
//
// per word: the word is taken, six products go through one shared multiplier, then
// the serial divider produces one quotient bit per cycle; a saturating quotient
// skips the divider loop, and a skipped segment bypasses the divider altogether.
// reset is synchronous and clears control state.
// a new word is taken while a result waits in the output register; a second result
// stalls the sequencer until the first is taken.
// depends on rsnh_pkg, rsnh_div, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ray_segment_nearest_hit_unit #(
  parameter int COORD_WIDTH   = rsnh_pkg::COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = rsnh_pkg::DIR_FRAC_BITS_DEF,
  localparam int IN_DW = ((6 * COORD_WIDTH + 2 * rsnh_pkg::DIR_WIDTH
                          + rsnh_pkg::LEN_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // origin_x, origin_y, dir_x, dir_y, max_length,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, zero fill
  input  logic [IN_DW-1:0]                in_tdata,
  input  logic                            in_tuser,   // first_segment
  input  logic                            in_tlast,   // last_segment
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // distance, zero fill
  output logic [23:0]                     out_tdata,
  output logic                            out_tuser,  // hit
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [rsnh_pkg::THR_WIDTH-1:0]  cfg_wdata
);
  import rsnh_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int MW   = (DW > DIR_WIDTH) ? DW : DIR_WIDTH;
  localparam int AW   = 2 * MW + 1;
  localparam int QW   = CW - 1;
  localparam int CMPW = (QW > LEN_WIDTH) ? QW : LEN_WIDTH;
  localparam int OB_DY = 2 * CW + DIR_WIDTH;
  localparam int OB_ML = 2 * CW + 2 * DIR_WIDTH;
  localparam int OB_SX = OB_ML + LEN_WIDTH;

  // input field slices
  logic signed [CW-1:0]        f_ox, f_oy, f_sx, f_sy, f_ex, f_ey;
  logic signed [DIR_WIDTH-1:0] f_dx, f_dy;
  logic [LEN_WIDTH-1:0]        f_ml;

  assign f_ox = in_tdata[CW-1:0];
  assign f_oy = in_tdata[2*CW-1:CW];
  assign f_dx = in_tdata[2*CW+DIR_WIDTH-1:2*CW];
  assign f_dy = in_tdata[OB_DY+DIR_WIDTH-1:OB_DY];
  assign f_ml = in_tdata[OB_ML+LEN_WIDTH-1:OB_ML];
  assign f_sx = in_tdata[OB_SX+CW-1:OB_SX];
  assign f_sy = in_tdata[OB_SX+2*CW-1:OB_SX+CW];
  assign f_ex = in_tdata[OB_SX+3*CW-1:OB_SX+2*CW];
  assign f_ey = in_tdata[OB_SX+4*CW-1:OB_SX+3*CW];

  state_t state_r, state_nxt;

  logic signed [DW-1:0]        v1x_r, v1y_r, v2x_r, v2y_r;
  logic signed [DIR_WIDTH-1:0] dx_r, dy_r;
  logic [LEN_WIDTH-1:0]        ml_r;
  logic                        last_r;
  logic [THR_WIDTH-1:0]        thr_r;
  logic [LEN_WIDTH-1:0]        best_r, best_nxt;
  logic                        any_r, any_nxt;
  logic [2:0]                  step_r;
  logic signed [2*MW-1:0]      prod_r;
  logic [1:0]                  psel_r;
  logic                        pneg_r;
  logic signed [AW-1:0]        den_r, num1_r, num2_r;
  logic [LEN_WIDTH-1:0]        odist_r;
  logic                        ohit_r, ovalid_r;

  logic                        accept;
  logic signed [MW-1:0]        op_a, op_b;
  logic signed [AW-1:0]        prod_ext;
  logic [AW-1:0]               mden, mnum1, mnum2;
  logic                        dneg, t1_ok, t2_ok, seg_ok;
  logic                        div_start;
  logic [QW-1:0]               div_q;
  div_stat_t                   div_st;
  logic [CMPW-1:0]             q_ext, best_ext;
  logic                        out_free, emit_load;

  assign accept = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MUL;
      S_MUL:  if (step_r == 3'd6) state_nxt = S_TEST;
      S_TEST: state_nxt = seg_ok ? S_DIV : S_EMIT;
      S_DIV:  if (div_st.done) state_nxt = S_EMIT;
      S_EMIT: if (!last_r || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_TEST: div_start = seg_ok;
      S_EMIT: emit_load = last_r && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (step_r)
      3'd0: begin op_a = MW'(v2y_r); op_b = MW'(dx_r);  end
      3'd1: begin op_a = MW'(v2x_r); op_b = MW'(dy_r);  end
      3'd2: begin op_a = MW'(v2x_r); op_b = MW'(v1y_r); end
      3'd3: begin op_a = MW'(v2y_r); op_b = MW'(v1x_r); end
      3'd4: begin op_a = MW'(v1y_r); op_b = MW'(dx_r);  end
      3'd5: begin op_a = MW'(v1x_r); op_b = MW'(dy_r);  end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_ext = AW'(prod_r);

  // magnitudes and the hit tests
  assign mden  = den_r[AW-1]  ? AW'(-den_r)  : AW'(den_r);
  assign mnum1 = num1_r[AW-1] ? AW'(-num1_r) : AW'(num1_r);
  assign mnum2 = num2_r[AW-1] ? AW'(-num2_r) : AW'(num2_r);
  assign dneg  = den_r[AW-1];
  assign t1_ok = (num1_r == '0) || (num1_r[AW-1] == dneg);
  assign t2_ok = ((num2_r == '0) || (num2_r[AW-1] == dneg)) && (mnum2 <= mden);
  assign seg_ok = (mden != '0) && (mden >= AW'(thr_r)) && t1_ok && t2_ok;

  // divider captures the magnitudes at its start
  rsnh_div #(
    .NW   (AW),
    .QW   (QW),
    .FRAC (DIR_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mnum1),
    .den   (mden),
    .quo   (div_q),
    .stat  (div_st)
  );

  assign q_ext    = CMPW'(div_q);
  assign best_ext = CMPW'(best_r);
  assign out_free = !ovalid_r || out_tready;

  // running minimum and hit flag
  always_comb begin
    best_nxt = best_r;
    any_nxt  = any_r;
    if (accept && in_tuser) begin
      best_nxt = f_ml;
      any_nxt  = 1'b0;
    end else if (state_r == S_DIV && div_st.done && q_ext <= best_ext) begin
      best_nxt = q_ext[LEN_WIDTH-1:0];
      any_nxt  = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      best_r   <= '0;
      any_r    <= 1'b0;
      ovalid_r <= 1'b0;
      step_r   <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      best_r <= best_nxt;
      any_r  <= any_nxt;
      if (emit_load)       ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (state_r == S_MUL) step_r <= step_r + 3'd1;
      else                  step_r <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      v1x_r  <= DW'(f_ox) - DW'(f_sx);
      v1y_r  <= DW'(f_oy) - DW'(f_sy);
      v2x_r  <= DW'(f_ex) - DW'(f_sx);
      v2y_r  <= DW'(f_ey) - DW'(f_sy);
      dx_r   <= f_dx;
      dy_r   <= f_dy;
      ml_r   <= f_ml;
      last_r <= in_tlast;
      den_r  <= '0;
      num1_r <= '0;
      num2_r <= '0;
    end
    if (state_r == S_MUL) begin
      prod_r <= op_a * op_b;
      psel_r <= step_r[2:1];
      pneg_r <= step_r[0];
      if (step_r != 3'd0) begin
        case (psel_r)
          2'd0: den_r  <= pneg_r ? den_r  - prod_ext : den_r  + prod_ext;
          2'd1: num1_r <= pneg_r ? num1_r - prod_ext : num1_r + prod_ext;
          2'd2: num2_r <= pneg_r ? num2_r - prod_ext : num2_r + prod_ext;
          default: ;
        endcase
      end
    end
    if (emit_load) begin
      odist_r <= any_r ? best_r : ml_r;
      ohit_r  <= any_r;
    end
  end

  assign out_tdata  = {1'b0, odist_r};
  assign out_tuser  = ohit_r;
  assign out_tvalid = ovalid_r;

  `RSNH_ASSERT_IMP(a_div_done_in_div, div_st.done, state_r == S_DIV)
  `RSNH_ASSERT_IMP(a_accept_idle, accept, !div_st.busy)
  `RSNH_ASSERT_NXT(a_emit_valid, emit_load, out_tvalid)
  `RSNH_ASSERT_IMP(a_hit_clear, $fell(any_r), $past(accept && in_tuser))
endmodule

[rtl/core/rsnh_div.sv]
// radix-2 restoring divider, one quotient bit per cycle, saturating
// computes min(floor(num * 2^FRAC / den), 2^QW - 1); uses rsnh_pkg
`timescale 1ns / 1ps
module rsnh_div #(
  parameter int NW   = 33,
  parameter int QW   = 23,
  parameter int FRAC = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [NW-1:0]       den,
  output logic [QW-1:0]       quo,
  output rsnh_pkg::div_stat_t stat
);
  import rsnh_pkg::*;

  localparam int XW = NW + FRAC;
  localparam int CW = $clog2(QW + 1);

  logic [XW-1:0] scaled;
  logic [XW-1:0] high_part;
  logic          sat_now;
  logic [NW:0]   trial;
  logic          fits;

  logic [NW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] low_r, low_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [NW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          sat_r, sat_nxt;

  // dividend shifted by the fraction bits, split into a high part and serial low bits
  assign scaled    = {num, {FRAC{1'b0}}};
  assign high_part = scaled >> QW;
  assign sat_now   = (high_part >= XW'(den));

  // one trial subtract per cycle
  assign trial = {rem_r, low_r[QW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    if (start) begin
      den_nxt = den;
      rem_nxt = high_part[NW-1:0];
      low_nxt = scaled[QW-1:0];
      q_nxt   = '0;
      cnt_nxt = CW'(QW);
      sat_nxt = sat_now;
      if (sat_now) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? NW'(trial - {1'b0, den_r}) : trial[NW-1:0];
      low_nxt = {low_r[QW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    sat_r <= sat_nxt;
  end

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.sat  = sat_r;
endmodule
